/* rtl/core/rvdec_pkg.sv */
`default_nettype none

package rvdec_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned KindWidth = 6;

  // major opcodes, bits 6:0
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_FENCE  = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  localparam logic [6:0] F7_ZERO   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

  // instruction kinds
  localparam logic [KindWidth-1:0] KIND_LUI    = 6'd0;
  localparam logic [KindWidth-1:0] KIND_AUIPC  = 6'd1;
  localparam logic [KindWidth-1:0] KIND_JAL    = 6'd2;
  localparam logic [KindWidth-1:0] KIND_JALR   = 6'd3;
  localparam logic [KindWidth-1:0] KIND_BEQ    = 6'd4;
  localparam logic [KindWidth-1:0] KIND_BNE    = 6'd5;
  localparam logic [KindWidth-1:0] KIND_BLT    = 6'd6;
  localparam logic [KindWidth-1:0] KIND_BGE    = 6'd7;
  localparam logic [KindWidth-1:0] KIND_BLTU   = 6'd8;
  localparam logic [KindWidth-1:0] KIND_BGEU   = 6'd9;
  localparam logic [KindWidth-1:0] KIND_LB     = 6'd10;
  localparam logic [KindWidth-1:0] KIND_LH     = 6'd11;
  localparam logic [KindWidth-1:0] KIND_LW     = 6'd12;
  localparam logic [KindWidth-1:0] KIND_LBU    = 6'd13;
  localparam logic [KindWidth-1:0] KIND_LHU    = 6'd14;
  localparam logic [KindWidth-1:0] KIND_SB     = 6'd15;
  localparam logic [KindWidth-1:0] KIND_SH     = 6'd16;
  localparam logic [KindWidth-1:0] KIND_SW     = 6'd17;
  localparam logic [KindWidth-1:0] KIND_ADDI   = 6'd18;
  localparam logic [KindWidth-1:0] KIND_SLTI   = 6'd19;
  localparam logic [KindWidth-1:0] KIND_SLTIU  = 6'd20;
  localparam logic [KindWidth-1:0] KIND_XORI   = 6'd21;
  localparam logic [KindWidth-1:0] KIND_ORI    = 6'd22;
  localparam logic [KindWidth-1:0] KIND_ANDI   = 6'd23;
  localparam logic [KindWidth-1:0] KIND_SLLI   = 6'd24;
  localparam logic [KindWidth-1:0] KIND_SRLI   = 6'd25;
  localparam logic [KindWidth-1:0] KIND_SRAI   = 6'd26;
  localparam logic [KindWidth-1:0] KIND_ADD    = 6'd27;
  localparam logic [KindWidth-1:0] KIND_SLL    = 6'd28;
  localparam logic [KindWidth-1:0] KIND_SLT    = 6'd29;
  localparam logic [KindWidth-1:0] KIND_SLTU   = 6'd30;
  localparam logic [KindWidth-1:0] KIND_XOR    = 6'd31;
  localparam logic [KindWidth-1:0] KIND_SRL    = 6'd32;
  localparam logic [KindWidth-1:0] KIND_OR     = 6'd33;
  localparam logic [KindWidth-1:0] KIND_AND    = 6'd34;
  localparam logic [KindWidth-1:0] KIND_SUB    = 6'd35;
  localparam logic [KindWidth-1:0] KIND_SRA    = 6'd36;
  localparam logic [KindWidth-1:0] KIND_FENCE  = 6'd37;
  localparam logic [KindWidth-1:0] KIND_ECALL  = 6'd38;
  localparam logic [KindWidth-1:0] KIND_EBREAK = 6'd39;
  localparam logic [KindWidth-1:0] KIND_MUL    = 6'd40;
  localparam logic [KindWidth-1:0] KIND_UNDEF  = 6'd48;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [4:0]           dest_reg;
    logic [4:0]           src_reg_a;
    logic [4:0]           src_reg_b;
    logic [2:0]           func_low;
    logic [6:0]           func_high;
    logic [31:0]          immediate;
    logic [3:0]           fence_succ;
    logic [3:0]           fence_pred;
    logic [3:0]           fence_mode;
  } dec_result_t;

endpackage

`default_nettype wire

/* rtl/core/rvdec_decode.sv */
`default_nettype none

module rvdec_decode (
  input  wire logic [rvdec_pkg::WordWidth-1:0] word,
  input  wire logic                            mul_div_enable,
  output rvdec_pkg::dec_result_t               result
);
  import rvdec_pkg::*;

  logic [6:0]           opc;
  logic [2:0]           f3;
  logic [6:0]           f7;
  logic [31:0]          imm_i;
  logic [31:0]          imm_s;
  logic [31:0]          imm_b;
  logic [31:0]          imm_u;
  logic [31:0]          imm_j;
  logic [KindWidth-1:0] kind;
  logic [31:0]          imm;
  logic                 is_fence;

  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign f7  = word[31:25];

  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u = {word[31:12], 12'b0};
  assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

  always_comb begin
    kind     = KIND_UNDEF;
    is_fence = 1'b0;
    unique case (opc)
      OPC_LUI:    kind = KIND_LUI;
      OPC_AUIPC:  kind = KIND_AUIPC;
      OPC_JAL:    kind = KIND_JAL;
      OPC_JALR:   kind = KIND_JALR;
      OPC_BRANCH: begin
        unique case (f3)
          3'd0:    kind = KIND_BEQ;
          3'd1:    kind = KIND_BNE;
          3'd4:    kind = KIND_BLT;
          3'd5:    kind = KIND_BGE;
          3'd6:    kind = KIND_BLTU;
          3'd7:    kind = KIND_BGEU;
          default: kind = KIND_UNDEF;
        endcase
      end
      OPC_LOAD: begin
        unique case (f3)
          3'd0:    kind = KIND_LB;
          3'd1:    kind = KIND_LH;
          3'd2:    kind = KIND_LW;
          3'd4:    kind = KIND_LBU;
          3'd5:    kind = KIND_LHU;
          default: kind = KIND_UNDEF;
        endcase
      end
      OPC_STORE: begin
        unique case (f3)
          3'd0:    kind = KIND_SB;
          3'd1:    kind = KIND_SH;
          3'd2:    kind = KIND_SW;
          default: kind = KIND_UNDEF;
        endcase
      end
      OPC_OPIMM: begin
        unique case (f3)
          3'd0: kind = KIND_ADDI;
          3'd1: kind = KIND_SLLI;  // shamt upper bits not checked
          3'd2: kind = KIND_SLTI;
          3'd3: kind = KIND_SLTIU;
          3'd4: kind = KIND_XORI;
          3'd5: begin
            if (f7 == F7_ZERO) begin
              kind = KIND_SRLI;
            end else if (f7 == F7_ALT) begin
              kind = KIND_SRAI;
            end
          end
          3'd6: kind = KIND_ORI;
          3'd7: kind = KIND_ANDI;
          default: kind = KIND_UNDEF;
        endcase
      end
      OPC_OP: begin
        if (f7 == F7_ZERO) begin
          unique case (f3)
            3'd0:    kind = KIND_ADD;
            3'd1:    kind = KIND_SLL;
            3'd2:    kind = KIND_SLT;
            3'd3:    kind = KIND_SLTU;
            3'd4:    kind = KIND_XOR;
            3'd5:    kind = KIND_SRL;
            3'd6:    kind = KIND_OR;
            default: kind = KIND_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) begin
            kind = KIND_SUB;
          end else if (f3 == 3'd5) begin
            kind = KIND_SRA;
          end
        end else if (f7 == F7_MULDIV && mul_div_enable) begin
          // MUL..REMU follow funct3 in order
          kind = KIND_MUL + {3'b000, f3};
        end
      end
      OPC_FENCE: begin
        kind     = KIND_FENCE;
        is_fence = 1'b1;
      end
      OPC_SYSTEM: begin
        if (word[31:20] == SYS_ECALL) begin
          kind = KIND_ECALL;
        end else if (word[31:20] == SYS_EBREAK) begin
          kind = KIND_EBREAK;
        end
      end
      default: kind = KIND_UNDEF;
    endcase
  end

  // immediate format follows the decoded kind; undefined and R-type give zero
  always_comb begin
    imm = '0;
    if (kind != KIND_UNDEF) begin
      unique case (opc)
        OPC_LUI, OPC_AUIPC: imm = imm_u;
        OPC_JAL:            imm = imm_j;
        OPC_BRANCH:         imm = imm_b;
        OPC_STORE:          imm = imm_s;
        OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_FENCE, OPC_SYSTEM: imm = imm_i;
        default:            imm = '0;
      endcase
    end
  end

  always_comb begin
    result.kind       = kind;
    result.dest_reg   = word[11:7];
    result.src_reg_a  = word[19:15];
    result.src_reg_b  = word[24:20];
    result.func_low   = f3;
    result.func_high  = f7;
    result.immediate  = imm;
    result.fence_succ = is_fence ? word[23:20] : 4'b0;
    result.fence_pred = is_fence ? word[27:24] : 4'b0;
    result.fence_mode = is_fence ? word[31:28] : 4'b0;
  end

endmodule

`default_nettype wire

/* rtl/core/rv32im_instruction_decoder_core.sv */
`default_nettype none
// From the start beat to the done strobe: input register, decode logic, result
// register.
// Throughput: one instruction per cycle; busy is never asserted and the
// receiver cannot stall.
// Reset (rst, synchronous): clears the pipeline valid bits and sets
// mul_div_enable to 1.

module rv32im_instruction_decoder_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [rvdec_pkg::WordWidth-1:0]     instruction_word,
  input  wire logic                                cfg_write_en,
  input  wire logic                                cfg_write_data,
  output logic                                     done,
  output logic [rvdec_pkg::KindWidth-1:0]          kind,
  output logic [4:0]                               dest_reg,
  output logic [4:0]                               src_reg_a,
  output logic [4:0]                               src_reg_b,
  output logic [2:0]                               func_low,
  output logic [6:0]                               func_high,
  output logic signed [31:0]                       immediate,
  output logic [3:0]                               fence_succ,
  output logic [3:0]                               fence_pred,
  output logic [3:0]                               fence_mode
);
  import rvdec_pkg::*;

  logic                 mul_div_enable;
  logic                 in_valid;
  logic [WordWidth-1:0] in_word;
  logic                 out_valid;
  dec_result_t          dec_next;
  dec_result_t          out_result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_div_enable <= 1'b1;
    end else if (cfg_write_en) begin
      mul_div_enable <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= start;
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_word <= instruction_word;
    end
    if (in_valid) begin
      out_result <= dec_next;
    end
  end

  rvdec_decode u_decode (
    .word           (in_word),
    .mul_div_enable (mul_div_enable),
    .result         (dec_next)
  );

  assign done       = out_valid;
  assign kind       = out_result.kind;
  assign dest_reg   = out_result.dest_reg;
  assign src_reg_a  = out_result.src_reg_a;
  assign src_reg_b  = out_result.src_reg_b;
  assign func_low   = out_result.func_low;
  assign func_high  = out_result.func_high;
  assign immediate  = out_result.immediate;
  assign fence_succ = out_result.fence_succ;
  assign fence_pred = out_result.fence_pred;
  assign fence_mode = out_result.fence_mode;

endmodule

`default_nettype wire
